FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

FILE: hdl/cb94_pkg.sv
// Types and constants for the chunked base-94 candidate generator.
// No dependencies.
package cb94_pkg;
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_DIST = 2'd1;
    localparam logic [1:0] OP_ADV  = 2'd2;
    localparam logic [1:0] OP_READ = 2'd3;
    localparam logic [6:0] CH_MIN = 7'd33;
    localparam logic [6:0] CH_MAX = 7'd126;
    localparam logic [15:0] CHUNK_RESET = 16'd5000;
    localparam int BASE = 94;

    typedef struct packed {
        logic [1:0] operation;
        logic [2:0] slot_index;
        logic [4:0] char_position;
        logic [6:0] char_value;
    } in_item_t;

    typedef struct packed {
        logic [6:0] char_out;
        logic [4:0] position_out;
        logic       last;
    } out_item_t;
endpackage

FILE: hdl/cb94_digit_add.sv
// One base-94 digit step: digit plus carry, next digit and carry out.
// Depends on cb94_pkg.
module cb94_digit_add
(
    input  logic [6:0]  ch,
    input  logic [15:0] carry,
    output logic [6:0]  ch_new,
    output logic [15:0] carry_new
);
    import cb94_pkg::*;
    logic [16:0] sum;
    logic [16:0] q;
    logic [33:0] prod;
    logic [16:0] r;
    always_comb
    begin
        if (ch == 7'd0)
            sum = {1'b0, carry} - 17'd1;
        else
            sum = {1'b0, carry} + {10'd0, ch} - 17'd33;
        // 44620 = floor(2^22/94): quotient low by at most one for sum < 2^17
        prod = {17'd0, sum} * 34'd44620;
        q = 17'(prod >> 22);
        r = sum - 17'(q * 17'd94);
        if (r >= 17'd94)
        begin
            r = r - 17'd94;
            q = q + 17'd1;
        end
        ch_new = 7'(r) + CH_MIN;
        carry_new = q[15:0];
    end
endmodule

FILE: hdl/chunked_base94_candidate_generator_top.sv
// Chunked base-94 candidate generator, one item at a time; next item taken once
// the last result has left. Each operation is a serial walk over one char
// memory: load writes one char (clearing the shared row first at position 0);
// advance, take chunk and distribute walk row positions, distribute for every
// slot; read walks the slot string. Reset: async, clears control; char memory
// swept to zero while inputs are stalled.
module chunked_base94_candidate_generator_top #(
    parameter int MAX_CHARS = 29,
    parameter int NUM_SLOTS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  cb94_pkg::in_item_t   in_item,
    output logic                 out_valid,
    input  logic                 out_stall,
    output cb94_pkg::out_item_t  out_item,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [1:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import cb94_pkg::*;
    `include "assert_macros.svh"

    localparam int PW = $clog2(MAX_CHARS + 1);
    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int ROWS = NUM_SLOTS + 1;
    localparam int RW = $clog2(ROWS + 1);
    localparam int DEPTH = ROWS * MAX_CHARS;
    localparam int AW = $clog2(DEPTH);
    localparam logic [RW-1:0] SHARED_ROW = RW'(NUM_SLOTS);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_LD, S_TK_RD, S_TK_CP, S_AD_RD, S_AD_WR,
        S_RD_RD, S_RD_EM, S_ACK
    } state_t;

    logic [15:0] chunk_reg;
    logic [15:0] quota_reg [NUM_SLOTS];
    logic [6:0]  mem [DEPTH];
    logic [6:0]  rdata;
    logic        we;
    logic [AW-1:0] waddr, raddr;
    logic [6:0]  wdata;

    state_t      state_reg;
    in_item_t    item_reg;
    logic [RW-1:0] slot_reg;
    logic [PW-1:0] pos_reg;
    logic [15:0] carry_reg;
    logic        ended_reg;
    logic        dist_reg;
    logic        ov_reg;
    out_item_t   ov_item_reg;
    logic [AW-1:0] clr_reg;
    logic        first_reg;
    logic [6:0]  hold_reg;

    logic [6:0]  add_ch;
    logic [15:0] add_carry;
    logic        rd_end;
    logic        ov_load;

    function automatic logic [AW-1:0] addr_of(logic [RW-1:0] row, logic [PW-1:0] p);
        return AW'(row * MAX_CHARS + p);
    endfunction

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {16'd0, chunk_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            chunk_reg <= CHUNK_RESET;
        else if (psel && penable && pwrite && paddr == 2'd0)
            chunk_reg <= pwdata[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

    // current char for add: empty once string ended
    cb94_digit_add u_add (
        .ch        (ended_reg ? 7'd0 : rdata),
        .carry     (carry_reg),
        .ch_new    (add_ch),
        .carry_new (add_carry)
    );

    assign in_stall = (state_reg != S_IDLE) || ov_reg;
    assign out_valid = ov_reg;
    assign out_item = ov_item_reg;

    logic out_free;
    assign out_free = !ov_reg || !out_stall;

    // read walk ends at the first empty char or past the last position
    assign rd_end = (rdata == 7'd0) || (pos_reg == PW'(MAX_CHARS));
    assign ov_load = out_free && ((state_reg == S_ACK) ||
                     (state_reg == S_RD_EM && (pos_reg != '0 || rd_end)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (ov_load)
            ov_reg <= 1'b1;
        else if (!out_stall)
            ov_reg <= 1'b0;
    end

    // memory port control
    always_comb
    begin
        we = 1'b0;
        waddr = '0;
        wdata = '0;
        raddr = '0;
        unique case (state_reg)
            S_CLR:
            begin
                we = 1'b1;
                waddr = clr_reg;
            end
            S_LD:
            begin
                we = 1'b1;
                waddr = addr_of(SHARED_ROW, pos_reg);
                if (first_reg || item_reg.char_value == 7'd0)
                    wdata = 7'd0;
                else if (item_reg.char_value < CH_MIN)
                    wdata = CH_MIN;
                else if (item_reg.char_value > CH_MAX)
                    wdata = CH_MAX;
                else
                    wdata = item_reg.char_value;
            end
            S_TK_RD, S_AD_RD, S_RD_RD, S_RD_EM:
            begin
                raddr = (state_reg == S_TK_RD) ? addr_of(SHARED_ROW, pos_reg)
                                               : addr_of(slot_reg, pos_reg);
            end
            S_TK_CP:
            begin
                // copy to slot row (first_reg=1), else zero shared past its end
                we = 1'b1;
                if (first_reg)
                begin
                    waddr = addr_of(slot_reg, pos_reg);
                    wdata = ended_reg ? 7'd0 : rdata;
                end
                else
                begin
                    waddr = addr_of(SHARED_ROW, pos_reg);
                    wdata = (ended_reg || rdata == 7'd0) ? 7'd0 : rdata;
                end
            end
            S_AD_WR:
            begin
                // zero chunk leaves the shared string as it is
                we = first_reg || chunk_reg != 16'd0;
                waddr = addr_of(dist_reg || quota_reg[slot_reg[SW-1:0]] == 16'd0
                                ? SHARED_ROW : slot_reg, pos_reg);
                wdata = add_ch;
                if (first_reg)
                    wdata = (rdata >= CH_MAX) ? CH_MIN
                          : (rdata == 7'd0 ? CH_MIN : rdata + 7'd1);
            end
            default: ;
        endcase
    end

    // Take chunk: pass 1 (S_TK_RD/S_TK_CP, first_reg=1) copies shared to slot
    // and zeroes shared past its first zero in pass 2 (first_reg=0), then
    // pass 3 adds chunk into shared from the slot copy (S_AD_RD/S_AD_WR,
    // carry, first_reg=0). Advance in place: S_AD_RD/S_AD_WR, first_reg=1.
    logic take_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_reg <= '0;
            ov_item_reg <= '0;
            item_reg <= '0;
            slot_reg <= '0;
            pos_reg <= '0;
            carry_reg <= '0;
            ended_reg <= 1'b0;
            dist_reg <= 1'b0;
            first_reg <= 1'b0;
            take_mode_reg <= 1'b0;
            hold_reg <= '0;
            for (int i = 0; i < NUM_SLOTS; i++)
                quota_reg[i] <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (clr_reg == AW'(DEPTH - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_valid && !in_stall)
                    begin
                        item_reg <= in_item;
                        pos_reg <= (in_item.operation == OP_LOAD)
                                   ? PW'(in_item.char_position) : '0;
                        ended_reg <= 1'b0;
                        slot_reg <= (in_item.operation == OP_DIST)
                                    ? '0 : RW'(in_item.slot_index);
                        unique case (in_item.operation)
                            OP_LOAD:
                            begin
                                if (in_item.char_position == 5'd0)
                                begin
                                    state_reg <= S_LD;
                                    first_reg <= 1'b1;
                                end
                                else if (32'(in_item.char_position) < MAX_CHARS)
                                begin
                                    first_reg <= 1'b0;
                                    state_reg <= S_LD;
                                end
                                else
                                    state_reg <= S_ACK;
                            end
                            OP_DIST:
                            begin
                                dist_reg <= 1'b1;
                                first_reg <= 1'b1;
                                state_reg <= S_TK_RD;
                            end
                            OP_ADV:
                            begin
                                dist_reg <= 1'b0;
                                if (32'(in_item.slot_index) >= NUM_SLOTS)
                                    state_reg <= S_ACK;
                                else if (quota_reg[in_item.slot_index[SW-1:0]] == 16'd0)
                                begin
                                    first_reg <= 1'b1;
                                    state_reg <= S_TK_RD;
                                end
                                else
                                begin
                                    first_reg <= 1'b1;
                                    take_mode_reg <= 1'b0;
                                    state_reg <= S_AD_RD;
                                end
                            end
                            OP_READ:
                            begin
                                if (32'(in_item.slot_index) >= NUM_SLOTS)
                                    state_reg <= S_ACK;
                                else
                                    state_reg <= S_RD_RD;
                            end
                            default: state_reg <= S_ACK;
                        endcase
                    end
                end
                S_LD:
                begin
                    // position 0: clear whole row, then write char 0
                    if (first_reg)
                    begin
                        if (pos_reg == PW'(MAX_CHARS - 1))
                        begin
                            first_reg <= 1'b0;
                            pos_reg <= '0;
                        end
                        else
                            pos_reg <= pos_reg + PW'(1);
                    end
                    else
                        state_reg <= S_ACK;
                end
                S_TK_RD: state_reg <= S_TK_CP;
                S_TK_CP:
                begin
                    if (pos_reg == PW'(MAX_CHARS - 1))
                    begin
                        pos_reg <= '0;
                        ended_reg <= 1'b0;
                        if (first_reg)
                        begin
                            first_reg <= 1'b0;
                            state_reg <= S_TK_RD;
                        end
                        else if (chunk_reg == 16'd0)
                            state_reg <= S_AD_WR;
                        else
                        begin
                            take_mode_reg <= 1'b1;
                            carry_reg <= chunk_reg;
                            state_reg <= S_AD_RD;
                        end
                    end
                    else
                    begin
                        if (!ended_reg && rdata == 7'd0)
                            ended_reg <= 1'b1;
                        pos_reg <= pos_reg + PW'(1);
                        state_reg <= S_TK_RD;
                    end
                end
                S_AD_RD: state_reg <= S_AD_WR;
                S_AD_WR:
                begin
                    logic done;
                    done = 1'b0;
                    if (take_mode_reg || (state_reg == S_AD_WR && !first_reg))
                    begin
                        if (chunk_reg != 16'd0)
                        begin
                            carry_reg <= add_carry;
                            if (add_carry == 16'd0 || pos_reg == PW'(MAX_CHARS - 1))
                                done = 1'b1;
                        end
                        else
                            done = 1'b1;
                        if (done)
                        begin
                            quota_reg[slot_reg[SW-1:0]] <=
                                (chunk_reg == 16'd0) ? 16'd0 : chunk_reg - 16'd1;
                            take_mode_reg <= 1'b0;
                            if (dist_reg && slot_reg != RW'(NUM_SLOTS - 1))
                            begin
                                slot_reg <= slot_reg + RW'(1);
                                pos_reg <= '0;
                                ended_reg <= 1'b0;
                                first_reg <= 1'b1;
                                state_reg <= S_TK_RD;
                            end
                            else
                            begin
                                dist_reg <= 1'b0;
                                state_reg <= S_ACK;
                            end
                        end
                        else
                        begin
                            if (!ended_reg && rdata == 7'd0)
                                ended_reg <= 1'b1;
                            pos_reg <= pos_reg + PW'(1);
                            state_reg <= S_AD_RD;
                        end
                    end
                    else
                    begin
                        if (rdata < CH_MAX || pos_reg == PW'(MAX_CHARS - 1))
                        begin
                            quota_reg[slot_reg[SW-1:0]] <=
                                quota_reg[slot_reg[SW-1:0]] - 16'd1;
                            state_reg <= S_ACK;
                        end
                        else
                        begin
                            pos_reg <= pos_reg + PW'(1);
                            state_reg <= S_AD_RD;
                        end
                    end
                end
                S_RD_RD: state_reg <= S_RD_EM;
                S_RD_EM:
                begin
                    // char at pos_reg-1 goes out once char at pos_reg is known
                    if (pos_reg == '0 && !rd_end)
                    begin
                        hold_reg <= rdata;
                        pos_reg <= pos_reg + PW'(1);
                        state_reg <= S_RD_RD;
                    end
                    else if (out_free)
                    begin
                        if (pos_reg == '0)
                            ov_item_reg <= '{char_out: 7'd0, position_out: 5'd0,
                                             last: 1'b1};
                        else
                            ov_item_reg <= '{char_out: hold_reg,
                                             position_out: 5'(pos_reg - PW'(1)),
                                             last: rd_end};
                        if (rd_end)
                            state_reg <= S_IDLE;
                        else
                        begin
                            hold_reg <= rdata;
                            pos_reg <= pos_reg + PW'(1);
                            state_reg <= S_RD_RD;
                        end
                    end
                end
                S_ACK:
                begin
                    if (out_free)
                    begin
                        ov_item_reg <= '{char_out: 7'd0, position_out: 5'd0, last: 1'b1};
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `ASSERT_IMPL(a_no_accept_busy, clk, rst_n, state_reg != S_IDLE, in_stall)
    `ASSERT_NEXT(a_ack_last, clk, rst_n, state_reg == S_ACK && out_free,
                 out_valid && out_item.last)
    `ASSERT_IMPL(a_no_write_idle, clk, rst_n, state_reg == S_IDLE, !we)
endmodule

FILE: sim/chunked_base94_candidate_generator_top_tb.sv
// Testbench for the chunked base-94 candidate generator top level.
// Predicts every result in the bench and checks each one, in order.
// Depends on hdl/cb94_pkg.sv and hdl/chunked_base94_candidate_generator_top.sv.
`timescale 1ns / 100ps

module chunked_base94_candidate_generator_top_tb;
    import cb94_pkg::*;

    localparam int NCH = 29;
    localparam int NSL = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_item_t    in_item = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_item_t   out_item;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_cycles = 0;
    int errors = 0;

    logic [15:0] chunk_sz;
    logic [6:0]  shared_str [NCH];
    logic [6:0]  cand [NSL][NCH];
    logic [15:0] quota [NSL];
    out_item_t   expected_chars [$];

    chunked_base94_candidate_generator_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #100_000_000;
        $display("chunked_base94_candidate_generator_top_tb: FAIL");
        $finish;
    end

    // receiver stall control
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_chars.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, out_item);
                errors++;
            end
            else
            begin
                want = expected_chars.pop_front();
                if (want !== out_item)
                begin
                    $display("%0t: mismatch expected ch=%0d pos=%0d last=%0d got ch=%0d pos=%0d last=%0d",
                             $time, want.char_out, want.position_out, want.last,
                             out_item.char_out, out_item.position_out, out_item.last);
                    errors++;
                end
            end
        end
    end

    function automatic void model_take_chunk(int s);
        logic [6:0] nxt [NCH];
        int carry;
        int sum;
        bit stop;
        stop = 0;
        for (int i = 0; i < NCH; i++)
        begin
            if (shared_str[i] == 0)
                stop = 1;
            nxt[i] = stop ? 7'd0 : shared_str[i];
        end
        cand[s] = nxt;
        carry = chunk_sz;
        if (carry != 0)
            for (int i = 0; i < NCH; i++)
            begin
                sum = (nxt[i] == 0) ? carry - 1 : carry + nxt[i] - CH_MIN;
                nxt[i] = 7'(CH_MIN + sum % BASE);
                carry = sum / BASE;
                if (carry == 0)
                    break;
            end
        shared_str = nxt;
        quota[s] = (chunk_sz == 0) ? 16'd0 : chunk_sz - 16'd1;
    endfunction

    function automatic void model_item(in_item_t it);
        int n;
        int s;
        logic [6:0] v;
        out_item_t r;
        n = 0;
        s = it.slot_index;
        r = '0;
        r.last = 1'b1;
        case (it.operation)
            OP_LOAD:
            begin
                if (it.char_position == 0)
                    foreach (shared_str[i]) shared_str[i] = '0;
                if (it.char_position < NCH)
                begin
                    v = it.char_value;
                    if (v != 0 && v < CH_MIN) v = CH_MIN;
                    if (v > CH_MAX) v = CH_MAX;
                    shared_str[it.char_position] = v;
                end
            end
            OP_DIST:
                for (int i = 0; i < NSL; i++) model_take_chunk(i);
            OP_ADV:
                if (quota[s] == 0)
                    model_take_chunk(s);
                else
                begin
                    for (int i = 0; i < NCH; i++)
                        if (cand[s][i] >= CH_MAX)
                            cand[s][i] = CH_MIN;
                        else
                        begin
                            cand[s][i] = (cand[s][i] == 0) ? CH_MIN : cand[s][i] + 7'd1;
                            break;
                        end
                    quota[s]--;
                end
            default:
            begin
                while (n < NCH && cand[s][n] != 0) n++;
                for (int i = 0; i < n; i++)
                begin
                    r.char_out = cand[s][i];
                    r.position_out = 5'(i);
                    r.last = (i == n - 1);
                    expected_chars.push_back(r);
                end
            end
        endcase
        if (n == 0)
            expected_chars.push_back(r);
    endfunction

    task automatic send_item(logic [1:0] op, logic [2:0] sl, logic [4:0] p, logic [6:0] v);
        in_item_t it;
        it = '{operation: op, slot_index: sl, char_position: p, char_value: v};
        while ($urandom_range(99) < send_idle_pct)
            @(negedge clk);
        in_valid = 1'b1;
        in_item = it;
        model_item(it);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (expected_chars.size() != 0 && guard < 2_000_000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (600) @(negedge clk);
    endtask

    task automatic write_chunk(logic [15:0] val);
        drain();
        psel <= 1'b1; pwrite <= 1'b1; paddr <= '0; pwdata <= {16'd0, val};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        chunk_sz = val;
    endtask

    task automatic send_random(int count);
        int k;
        for (k = 0; k < count; k++)
            case ($urandom_range(9))
                0, 1: send_item(OP_LOAD, 3'($urandom), 5'($urandom_range(31)), 7'($urandom));
                2: send_item(OP_DIST, 3'($urandom), 5'($urandom), 7'($urandom));
                3, 4, 5: send_item(OP_ADV, 3'($urandom), 5'($urandom), 7'($urandom));
                default: send_item(OP_READ, 3'($urandom), 5'($urandom), 7'($urandom));
            endcase
    endtask

    task automatic load_string(int len, bit top_heavy);
        for (int p = 0; p < len; p++)
            send_item(OP_LOAD, 3'($urandom), 5'(p),
                      top_heavy ? 7'd126 : 7'($urandom_range(33, 126)));
    endtask

    task automatic test_directed();
        send_item(OP_READ, 3'd0, 5'd0, 7'd0);
        send_item(OP_ADV, 3'd2, 5'd0, 7'd0);
        send_item(OP_READ, 3'd2, 5'd0, 7'd0);
        send_item(OP_LOAD, 3'd7, 5'd0, 7'd5);
        send_item(OP_LOAD, 3'd0, 5'd1, 7'd127);
        send_item(OP_LOAD, 3'd0, 5'd3, 7'd80);
        send_item(OP_LOAD, 3'd0, 5'd29, 7'd90);
        send_item(OP_LOAD, 3'd0, 5'd31, 7'd90);
        send_item(OP_DIST, 3'd0, 5'd31, 7'd127);
        send_item(OP_READ, 3'd7, 5'd0, 7'd0);
        send_item(OP_ADV, 3'd7, 5'd0, 7'd0);
        send_item(OP_READ, 3'd7, 5'd31, 7'd127);
        send_item(OP_LOAD, 3'd0, 5'd0, 7'd126);
        send_item(OP_LOAD, 3'd0, 5'd28, 7'd126);
        send_item(OP_ADV, 3'd5, 5'd0, 7'd0);
        send_item(OP_READ, 3'd5, 5'd0, 7'd0);
    endtask

    task automatic test_config_extremes();
        write_chunk(16'd0);
        load_string(NCH, 1);
        send_item(OP_DIST, 3'd0, 5'd0, 7'd0);
        send_item(OP_ADV, 3'd1, 5'd0, 7'd0);
        send_item(OP_READ, 3'd1, 5'd0, 7'd0);
        write_chunk(16'd1);
        send_item(OP_DIST, 3'd0, 5'd0, 7'd0);
        send_item(OP_READ, 3'd7, 5'd0, 7'd0);
        write_chunk(16'd65535);
        send_item(OP_DIST, 3'd0, 5'd0, 7'd0);
        send_item(OP_READ, 3'd7, 5'd0, 7'd0);
        send_item(OP_ADV, 3'd0, 5'd0, 7'd0);
        send_item(OP_READ, 3'd0, 5'd0, 7'd0);
    endtask

    task automatic test_random_phases();
        int idle [4] = '{0, 81, 0, 26};
        int stl [4] = '{0, 0, 81, 26};
        for (int ph = 0; ph < 4; ph++)
        begin
            write_chunk(16'(($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 200)));
            send_idle_pct = idle[ph];
            stall_pct = stl[ph];
            load_string($urandom_range(1, NCH), 1'($urandom_range(1)));
            send_random(($urandom_range(1) == 0) ? 70 : 80);
        end
        send_idle_pct = 0;
        stall_pct = 0;
    endtask

    task automatic test_backpressure();
        hold_cycles = 1500;
        for (int i = 0; i < 30; i++)
            send_item(OP_READ, 3'($urandom), 5'($urandom), 7'($urandom));
    endtask

    initial
    begin
        chunk_sz = CHUNK_RESET;
        foreach (shared_str[i]) shared_str[i] = '0;
        foreach (quota[s])
        begin
            quota[s] = '0;
            foreach (cand[s][i]) cand[s][i] = '0;
        end
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_config_extremes();
        test_random_phases();
        test_backpressure();
        drain();
        if (errors == 0 && expected_chars.size() == 0)
            $display("chunked_base94_candidate_generator_top_tb: PASS");
        else
            $display("chunked_base94_candidate_generator_top_tb: FAIL");
        $finish;
    end
endmodule
